/* sv/lps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

	// LEDs per row; the rows are always byte registers
	localparam int LEDS = 5;

	localparam int BYTE_W  = 8;
	localparam int MODE_W  = 5;
	localparam int SPEED_W = 3;
	localparam int WORD_W  = 2 * LEDS;
	localparam int STORE_W = 4 * LEDS + 1;
	localparam int BVIEW_W = 10;
	localparam int LVIEW_W = 13;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [MODE_W-1:0]  mode_t;
	typedef logic [SPEED_W-1:0] speed_t;
	typedef logic [STORE_W-1:0] store_t;
	typedef logic [BVIEW_W-1:0] bview_t;
	typedef logic [LVIEW_W-1:0] lview_t;

	// configuration register indexes
	typedef logic cfg_idx_t;
	localparam cfg_idx_t CFG_DEFAULT_PERIOD = 1'b0;
	localparam cfg_idx_t CFG_PERIOD_LIMIT   = 1'b1;

	// mode bits, lowest set bit wins
	localparam int MODE_FILL    = 0;
	localparam int MODE_FWD     = 1;
	localparam int MODE_BWD     = 2;
	localparam int MODE_BOUNCE  = 3;
	localparam int MODE_MIRROR  = 4;

	// speed button bits
	localparam int SPD_SLOWER  = 0;
	localparam int SPD_FASTER  = 1;
	localparam int SPD_RESTORE = 2;

	// reset values
	localparam mode_t MODE_RESET     = mode_t'(1);
	localparam byte_t PERIOD_RESET   = byte_t'(20);
	localparam byte_t LIMIT_RESET    = byte_t'(200);

	localparam byte_t  ROW_MASK  = byte_t'((1 << LEDS) - 1);
	localparam byte_t  TOP_BIT   = byte_t'(1 << (LEDS - 1));
	localparam store_t WORD_MASK = store_t'((64'd1 << WORD_W) - 64'd1);
	localparam store_t WRAP_BIT  = store_t'(64'd1 << WORD_W);

endpackage

`default_nettype wire

/* sv/led_pattern_sequencer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake             | Word
// ---------+-----------------------+---------------------------------------------
// input    | in_valid / in_stall   | bus_in_byte, select0, select1, select2
// output   | out_valid / out_stall | row_one, row_two, own_out, button_view,
//          |                       | button_changed, led_view, led_changed
// config   | cfg_wr_en             | cfg_index, cfg_data
//
// One input word per cycle while in_stall is low; each word is registered on entry
// and its result is then registered in the result register.
// The whole tick (mode pick, pattern step, counter, speed buttons, views) is
// computed between the input register and the result register.
// arst_n clears all control state and restores period 20, limit 200.
// in_stall rises only when both the input and the result register are full
// and the output is stalled.

module led_pattern_sequencer_unit (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_wr_en,
	input  wire lps_pkg::cfg_idx_t  cfg_index,
	input  wire lps_pkg::byte_t     cfg_data,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire lps_pkg::byte_t     bus_in_byte,
	input  wire lps_pkg::byte_t     select0,
	input  wire lps_pkg::byte_t     select1,
	input  wire lps_pkg::byte_t     select2,
	output logic                    out_valid,
	input  wire                     out_stall,
	output lps_pkg::byte_t          row_one,
	output lps_pkg::byte_t          row_two,
	output lps_pkg::byte_t          own_out,
	output lps_pkg::bview_t         button_view,
	output logic                    button_changed,
	output lps_pkg::lview_t         led_view,
	output logic                    led_changed
);
	import lps_pkg::*;

	// input stage
	logic  valid_s1;
	byte_t bus_s1, sel0_s1, sel1_s1, sel2_s1;

	// result stage
	logic   valid_s2;
	byte_t  row_one_s2, row_two_s2, own_s2;
	bview_t bview_s2;
	logic   bchg_s2;
	lview_t lview_s2;
	logic   lchg_s2;

	// block state
	byte_t  default_q, limit_q;
	mode_t  mode_q;
	byte_t  tick_q, period_q;
	logic   dir_q;
	store_t word_q;
	byte_t  row0_q, row1_q, own_q;
	speed_t latch_q;
	bview_t last_bview_q;
	lview_t last_lview_q;

	logic in_acc, adv;

	// next-state values
	mode_t  mode_d;
	byte_t  tick_d, period_d;
	logic   dir_d;
	store_t word_d;
	byte_t  row0_d, row1_d, own_d;
	speed_t latch_d;
	bview_t bview_d;
	lview_t lview_d;
	logic   step;
	byte_t  msel;
	speed_t speed;

	assign in_acc   = in_valid && !in_stall;
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	// take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= PERIOD_RESET;
			limit_q   <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_DEFAULT_PERIOD: default_q <= cfg_data;
				CFG_PERIOD_LIMIT:   limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold the pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	// capture the input word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bus_s1  <= bus_in_byte;
			sel0_s1 <= select0;
			sel1_s1 <= select1;
			sel2_s1 <= select2;
		end
	end

	// work out one tick
	always_comb begin
		msel  = sel1_s1 | sel2_s1;
		speed = speed_t'(bus_s1 | sel0_s1);

		mode_d   = (msel[MODE_W-1:0] != '0) ? msel[MODE_W-1:0] : mode_q;
		dir_d    = dir_q;
		word_d   = word_q;
		row0_d   = row0_q;
		row1_d   = row1_q;
		own_d    = own_q;
		period_d = period_q;
		latch_d  = latch_q;

		step   = (tick_q <= byte_t'(1));
		tick_d = step ? period_q : tick_q - byte_t'(1);

		// advance the pattern on expiry
		if (step) begin
			priority if (mode_d[MODE_FILL]) begin
				if (dir_q) begin
					if ((word_q & WORD_MASK) == '0) begin
						word_d = store_t'(1);
					end else begin
						word_d = {word_q[STORE_W-2:0], 1'b1};
						if (word_d >= WORD_MASK)
							dir_d = 1'b0;
					end
				end else begin
					word_d = {word_q[STORE_W-2:0], 1'b0};
					if ((word_d & WORD_MASK) == '0)
						dir_d = 1'b1;
				end
				row0_d = byte_t'(word_d[LEDS-1:0]);
				row1_d = byte_t'(word_d[WORD_W-1:LEDS]);
			end else if (mode_d[MODE_FWD]) begin
				word_d = {word_q[STORE_W-2:0], 1'b0};
				if (word_d > WORD_MASK || word_d == '0)
					word_d = store_t'(1);
				row0_d = byte_t'(word_d[LEDS-1:0]);
				row1_d = byte_t'(word_d[WORD_W-1:LEDS]);
			end else if (mode_d[MODE_BWD]) begin
				word_d = word_q >> 1;
				if (word_d > WORD_MASK || word_d == '0)
					word_d = WRAP_BIT;
				row0_d = byte_t'(word_d[LEDS-1:0]);
				row1_d = byte_t'(word_d[WORD_W-1:LEDS]);
			end else if (mode_d[MODE_BOUNCE]) begin
				if (row0_q == '0) begin
					row0_d = byte_t'(1);
					dir_d  = 1'b1;
				end else if (dir_q) begin
					row0_d = row0_q << 1;
					if (row0_d >= TOP_BIT)
						dir_d = 1'b0;
				end else begin
					row0_d = row0_q >> 1;
					if (row0_d <= byte_t'(1))
						dir_d = 1'b1;
				end
				row1_d = row0_d;
			end else if (mode_d[MODE_MIRROR]) begin
				if (row0_q == '0 || row1_q == '0 || (row1_q & ~ROW_MASK) != '0) begin
					row0_d = byte_t'(1);
					row1_d = TOP_BIT;
					dir_d  = 1'b1;
				end else if (dir_q) begin
					row0_d = row0_q << 1;
					row1_d = row1_q >> 1;
					if (row0_d >= TOP_BIT)
						dir_d = 1'b0;
				end else begin
					row0_d = row0_q >> 1;
					row1_d = row1_q << 1;
					if (row0_d <= byte_t'(1))
						dir_d = 1'b1;
				end
			end else begin
			end
			own_d = row0_d;
		end

		// apply speed buttons once per press
		if (latch_q == '0) begin
			priority if (speed[SPD_SLOWER]) begin
				if (period_q < limit_q)
					period_d = period_q + byte_t'(1);
				latch_d = speed;
			end else if (speed[SPD_FASTER]) begin
				if (period_q > byte_t'(1))
					period_d = period_q - byte_t'(1);
				latch_d = speed;
			end else if (speed[SPD_RESTORE]) begin
				period_d = default_q;
				latch_d  = speed;
			end else begin
			end
		end else if (speed == '0) begin
			latch_d = '0;
		end

		// build the packed views
		bview_d = bview_t'(msel & ROW_MASK) | (bview_t'(sel0_s1 & ROW_MASK) << LEDS);
		lview_d = lview_t'(row0_d) | (lview_t'(row1_d) << LEDS);
	end

	// update block state as each word leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_RESET;
			tick_q       <= '0;
			period_q     <= PERIOD_RESET;
			dir_q        <= 1'b0;
			word_q       <= '0;
			row0_q       <= '0;
			row1_q       <= '0;
			own_q        <= '0;
			latch_q      <= '0;
			last_bview_q <= '0;
			last_lview_q <= '0;
		end else if (adv) begin
			mode_q       <= mode_d;
			tick_q       <= tick_d;
			period_q     <= period_d;
			dir_q        <= dir_d;
			word_q       <= word_d;
			row0_q       <= row0_d;
			row1_q       <= row1_d;
			own_q        <= own_d;
			latch_q      <= latch_d;
			last_bview_q <= bview_d;
			last_lview_q <= lview_d;
		end
	end

	// load the result register
	always_ff @(posedge clk) begin
		if (adv) begin
			row_one_s2 <= row0_d;
			row_two_s2 <= row1_d;
			own_s2     <= own_d;
			bview_s2   <= bview_d;
			bchg_s2    <= (bview_d != last_bview_q);
			lview_s2   <= lview_d;
			lchg_s2    <= (lview_d != last_lview_q);
		end
	end

	assign out_valid      = valid_s2;
	assign row_one        = row_one_s2;
	assign row_two        = row_two_s2;
	assign own_out        = own_s2;
	assign button_view    = bview_s2;
	assign button_changed = bchg_s2;
	assign led_view       = lview_s2;
	assign led_changed    = lchg_s2;

endmodule

`default_nettype wire

/* sv/lps_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lps_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     in_stall,
	input wire                     out_valid,
	input wire                     out_stall,
	input wire lps_pkg::byte_t     row_one,
	input wire lps_pkg::byte_t     row_two,
	input wire lps_pkg::byte_t     own_out,
	input wire lps_pkg::bview_t    button_view,
	input wire lps_pkg::lview_t    led_view
);
	import lps_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(led_view) && $stable(own_out)
			&& $stable(button_view))
		else $error("stalled result word changed");

	// input backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// led view packs both rows
	a_led_view: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> led_view == (lview_t'(row_one) | (lview_t'(row_two) << LEDS)))
		else $error("led view does not match rows");

endmodule

bind led_pattern_sequencer_unit lps_checker u_lps_checker (.*);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import lps_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int PRINT_CAP     = 40;

	typedef struct packed {
		byte_t  row_one;
		byte_t  row_two;
		byte_t  own_out;
		bview_t button_view;
		logic   button_changed;
		lview_t led_view;
		logic   led_changed;
	} led_frame_t;

	logic     clk;
	logic     arst_n;
	logic     cfg_wr_en;
	cfg_idx_t cfg_index;
	byte_t    cfg_data;
	logic     in_valid;
	logic     in_stall;
	byte_t    bus_in_byte;
	byte_t    select0;
	byte_t    select1;
	byte_t    select2;
	logic     out_valid;
	logic     out_stall;
	byte_t    row_one;
	byte_t    row_two;
	byte_t    own_out;
	bview_t   button_view;
	logic     button_changed;
	lview_t   led_view;
	logic     led_changed;

	// sequencer copy kept by the testbench
	byte_t  dflt_period;
	byte_t  period_cap;
	mode_t  seq_mode;
	byte_t  ticks_left;
	byte_t  step_period;
	logic   sweep_up;
	store_t chase_word;
	byte_t  led_row [2];
	byte_t  own_byte;
	speed_t button_latch;
	bview_t prev_bview;
	lview_t prev_lview;

	led_frame_t expected_frames [$];
	int         mismatch_count;
	int         cycle_count;

	led_pattern_sequencer_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.bus_in_byte    (bus_in_byte),
		.select0        (select0),
		.select1        (select1),
		.select2        (select2),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.row_one        (row_one),
		.row_two        (row_two),
		.own_out        (own_out),
		.button_view    (button_view),
		.button_changed (button_changed),
		.led_view       (led_view),
		.led_changed    (led_changed)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("led_pattern_sequencer_unit regression: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic split_chase_word();
		led_row[0] = byte_t'(chase_word[LEDS-1:0]);
		led_row[1] = byte_t'(chase_word[WORD_W-1:LEDS]);
	endtask

	// advance the pattern of the active mode by one step
	task automatic step_pattern();
		if (seq_mode[MODE_FILL]) begin
			if (sweep_up) begin
				if ((chase_word & WORD_MASK) == '0) begin
					chase_word = store_t'(1);
				end else begin
					chase_word = (chase_word << 1) + store_t'(1);
					if (chase_word >= WORD_MASK)
						sweep_up = 1'b0;
				end
			end else begin
				chase_word = chase_word << 1;
				if ((chase_word & WORD_MASK) == '0)
					sweep_up = 1'b1;
			end
			split_chase_word();
		end else if (seq_mode[MODE_FWD]) begin
			chase_word = chase_word << 1;
			if (chase_word > WORD_MASK || chase_word == '0)
				chase_word = store_t'(1);
			split_chase_word();
		end else if (seq_mode[MODE_BWD]) begin
			// wrap through the blank bit just above both rows
			chase_word = chase_word >> 1;
			if (chase_word > WORD_MASK || chase_word == '0)
				chase_word = WRAP_BIT;
			split_chase_word();
		end else if (seq_mode[MODE_BOUNCE]) begin
			if (led_row[0] == '0) begin
				led_row[0] = byte_t'(1);
				sweep_up = 1'b1;
			end else if (sweep_up) begin
				led_row[0] = led_row[0] << 1;
				if (led_row[0] >= TOP_BIT)
					sweep_up = 1'b0;
			end else begin
				led_row[0] = led_row[0] >> 1;
				if (led_row[0] <= byte_t'(1))
					sweep_up = 1'b1;
			end
			led_row[1] = led_row[0];
		end else if (seq_mode[MODE_MIRROR]) begin
			if (led_row[0] == '0 || led_row[1] == '0 || (led_row[1] & ~ROW_MASK) != '0) begin
				led_row[0] = byte_t'(1);
				led_row[1] = TOP_BIT;
				sweep_up = 1'b1;
			end else if (sweep_up) begin
				led_row[0] = led_row[0] << 1;
				led_row[1] = led_row[1] >> 1;
				if (led_row[0] >= TOP_BIT)
					sweep_up = 1'b0;
			end else begin
				led_row[0] = led_row[0] >> 1;
				led_row[1] = led_row[1] << 1;
				if (led_row[0] <= byte_t'(1))
					sweep_up = 1'b1;
			end
		end
		own_byte = led_row[0];
	endtask

	// work out the frame one tick word produces and queue it
	task automatic predict_tick(input byte_t bus, input byte_t s0, input byte_t s1,
			input byte_t s2);
		speed_t     speed;
		byte_t      msel;
		led_frame_t frame;
		speed = bus[SPEED_W-1:0] | s0[SPEED_W-1:0];
		msel = s1 | s2;
		if (msel[MODE_W-1:0] != '0)
			seq_mode = msel[MODE_W-1:0];
		if (ticks_left <= byte_t'(1)) begin
			step_pattern();
			ticks_left = step_period;
		end else begin
			ticks_left = ticks_left - byte_t'(1);
		end
		// speed buttons act only with the latch clear
		if (button_latch == '0) begin
			if (speed[SPD_SLOWER]) begin
				if (step_period < period_cap)
					step_period = step_period + byte_t'(1);
				button_latch = speed;
			end else if (speed[SPD_FASTER]) begin
				if (step_period > byte_t'(1))
					step_period = step_period - byte_t'(1);
				button_latch = speed;
			end else if (speed[SPD_RESTORE]) begin
				step_period = dflt_period;
				button_latch = speed;
			end
		end else if (speed == '0) begin
			button_latch = '0;
		end
		frame.row_one        = led_row[0];
		frame.row_two        = led_row[1];
		frame.own_out        = own_byte;
		frame.button_view    = {s0[LEDS-1:0], msel[LEDS-1:0]};
		frame.button_changed = (frame.button_view != prev_bview);
		frame.led_view       = lview_t'(led_row[0]) | (lview_t'(led_row[1]) << LEDS);
		frame.led_changed    = (frame.led_view != prev_lview);
		prev_bview = frame.button_view;
		prev_lview = frame.led_view;
		expected_frames.push_back(frame);
	endtask

	// predict on every accepted tick word
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			predict_tick(bus_in_byte, select0, select1, select2);
	end

	// compare each accepted result word with the oldest prediction
	always @(posedge clk) begin : frame_check
		led_frame_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				report_mismatch("result word with no prediction pending");
			end else begin
				want = expected_frames.pop_front();
				check_field("row_one", 16'(row_one), 16'(want.row_one));
				check_field("row_two", 16'(row_two), 16'(want.row_two));
				check_field("own_out", 16'(own_out), 16'(want.own_out));
				check_field("button_view", 16'(button_view), 16'(want.button_view));
				check_field("button_changed", 16'(button_changed),
					16'(want.button_changed));
				check_field("led_view", 16'(led_view), 16'(want.led_view));
				check_field("led_changed", 16'(led_changed), 16'(want.led_changed));
			end
		end
	end

	// receiver stall pattern: free runs, random stalls, short holds, toggles
	initial begin
		out_stall = 1'b0;
		forever begin
			case ($urandom_range(0, 3))
				0: begin
					@(negedge clk) out_stall <= 1'b0;
					repeat ($urandom_range(10, 60)) @(negedge clk);
				end
				1: begin
					repeat ($urandom_range(20, 60))
						@(negedge clk) out_stall <= ($urandom_range(0, 2) == 0);
				end
				2: begin
					@(negedge clk) out_stall <= 1'b1;
					repeat ($urandom_range(0, 5)) @(negedge clk);
					@(negedge clk) out_stall <= 1'b0;
				end
				default: begin
					repeat ($urandom_range(4, 20))
						@(negedge clk) out_stall <= ~out_stall;
				end
			endcase
		end
	end

	task automatic send_item(input byte_t bus, input byte_t s0, input byte_t s1,
			input byte_t s2);
		@(negedge clk);
		in_valid    <= 1'b1;
		bus_in_byte <= bus;
		select0     <= s0;
		select1     <= s1;
		select2     <= s2;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// hold the sender until every predicted word has come back
	task automatic wait_for_drain();
		@(negedge clk) in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input byte_t value);
		wait_for_drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk) cfg_wr_en <= 1'b0;
		case (idx)
			CFG_DEFAULT_PERIOD: dflt_period = value;
			CFG_PERIOD_LIMIT:   period_cap = value;
			default: ;
		endcase
	endtask

	task automatic set_periods(input byte_t dflt, input byte_t cap);
		write_register(CFG_DEFAULT_PERIOD, dflt);
		write_register(CFG_PERIOD_LIMIT, cap);
	endtask

	// random ticks: held speed buttons, rare mode changes, some noise words
	task automatic run_random_ticks(input int count);
		int                          burst_left;
		int                          bit_pick;
		speed_t                      held;
		speed_t                      split;
		logic [BYTE_W-SPEED_W-1:0]   s0_high;
		byte_t                       bus;
		byte_t                       s0;
		byte_t                       s1;
		byte_t                       s2;
		burst_left = 0;
		held = '0;
		s0_high = (BYTE_W - SPEED_W)'($urandom);
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 24);
				idle_gap($urandom_range(0, 6));
			end
			burst_left--;
			if ($urandom_range(0, 249) == 0)
				wait_for_drain();
			if (held != '0) begin
				case ($urandom_range(0, 9))
					0, 1, 2: held = '0;
					3:       held = speed_t'($urandom_range(1, 7));
					default: ;
				endcase
			end else if ($urandom_range(0, 9) == 0) begin
				held = speed_t'($urandom_range(1, 7));
			end
			split = speed_t'($urandom);
			if ($urandom_range(0, 6) == 0)
				s0_high = (BYTE_W - SPEED_W)'($urandom);
			bus = byte_t'($urandom);
			bus[SPEED_W-1:0] = held & split;
			s0 = {s0_high, (held & ~split) | (held & speed_t'($urandom))};
			s1 = byte_t'($urandom);
			s2 = byte_t'($urandom);
			s1[MODE_W-1:0] = '0;
			s2[MODE_W-1:0] = '0;
			if ($urandom_range(0, 59) == 0) begin
				bit_pick = $urandom_range(0, MODE_W - 1);
				if ($urandom_range(0, 1) == 0)
					s1[bit_pick] = 1'b1;
				else
					s2[bit_pick] = 1'b1;
			end
			if ($urandom_range(0, 49) == 0) begin
				bus = byte_t'($urandom);
				s0 = byte_t'($urandom);
				s1 = byte_t'($urandom);
				s2 = byte_t'($urandom);
			end
			send_item(bus, s0, s1, s2);
		end
	endtask

	task automatic press_restore();
		send_item(8'h00, 8'h04, 8'h00, 8'h00);
		send_item(8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	// all-zero and all-one words, alternating upper bits; first tick steps
	task automatic test_field_extremes();
		send_item(8'h00, 8'h00, 8'h00, 8'h00);
		send_item(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(8'h00, 8'h00, 8'h00, 8'h00);
		send_item(8'hA8, 8'h50, 8'hA0, 8'h40);
		send_item(8'h50, 8'hA8, 8'h40, 8'hA0);
	endtask

	// slow, held, release, fast, combined press, restore to a new default
	task automatic test_speed_buttons();
		send_item(8'h01, 8'h00, 8'h00, 8'h00);
		send_item(8'h00, 8'h02, 8'h00, 8'h00);
		send_item(8'h00, 8'h00, 8'h00, 8'h00);
		send_item(8'h00, 8'h02, 8'h00, 8'h00);
		send_item(8'h00, 8'h00, 8'h00, 8'h00);
		send_item(8'h06, 8'h00, 8'h00, 8'h00);
		send_item(8'h00, 8'h00, 8'h00, 8'h00);
		write_register(CFG_DEFAULT_PERIOD, 8'd1);
		press_restore();
	endtask

	// each mode from either select byte; lowest set bit wins
	task automatic test_mode_choice();
		for (int m = 0; m < MODE_W; m++) begin
			if (m % 2 == 0)
				send_item(8'h00, 8'h00, byte_t'(1 << m), 8'h00);
			else
				send_item(8'h00, 8'h00, 8'h00, byte_t'(1 << m));
			send_item(8'h00, 8'h00, 8'h00, 8'h00);
		end
		send_item(8'h00, 8'h00, 8'h0C, 8'h10);
		send_item(8'h00, 8'h00, 8'hE0, 8'h00);
	endtask

	task automatic test_random_patterns();
		set_periods(8'd2, 8'd6);
		press_restore();
		run_random_ticks(850);
	endtask

	// restore to zero: step every tick, speed-up leaves zero alone
	task automatic test_period_zero();
		set_periods(8'd0, 8'd255);
		press_restore();
		send_item(8'h02, 8'h00, 8'h00, 8'h00);
		send_item(8'h00, 8'h00, 8'h00, 8'h00);
		run_random_ticks(300);
	endtask

	// default above the cap: slow-down must not move the period
	task automatic test_period_above_limit();
		set_periods(8'd3, 8'd1);
		press_restore();
		send_item(8'h00, 8'h01, 8'h00, 8'h00);
		send_item(8'h00, 8'h00, 8'h00, 8'h00);
		run_random_ticks(250);
	endtask

	task automatic test_slowest_period();
		set_periods(8'd255, 8'd255);
		press_restore();
		run_random_ticks(150);
	endtask

	task automatic test_fastest_limits();
		set_periods(8'd1, 8'd1);
		press_restore();
		run_random_ticks(300);
	endtask

	initial begin
		mismatch_count = 0;
		cycle_count    = 0;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = CFG_DEFAULT_PERIOD;
		cfg_data       = '0;
		in_valid       = 1'b0;
		bus_in_byte    = '0;
		select0        = '0;
		select1        = '0;
		select2        = '0;
		dflt_period    = PERIOD_RESET;
		period_cap     = LIMIT_RESET;
		seq_mode       = MODE_RESET;
		ticks_left     = '0;
		step_period    = PERIOD_RESET;
		sweep_up       = 1'b0;
		chase_word     = '0;
		led_row[0]     = '0;
		led_row[1]     = '0;
		own_byte       = '0;
		button_latch   = '0;
		prev_bview     = '0;
		prev_lview     = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		test_field_extremes();
		test_speed_buttons();
		test_mode_choice();
		test_random_patterns();
		test_period_zero();
		test_period_above_limit();
		test_slowest_period();
		test_fastest_limits();

		wait_for_drain();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("led_pattern_sequencer_unit regression: pass");
		else
			$display("led_pattern_sequencer_unit regression: fail");
		$finish;
	end

endmodule

/* led_pattern_sequencer_unit.f */
sv/lps_pkg.sv
sv/led_pattern_sequencer_unit.sv
sv/lps_checker.sv
tb/tb.sv
